### sv/sawlc_pkg.sv
// Package: shared constants, codes and types of the LRU cache tag engine.
`default_nettype none
package sawlc_pkg;
    localparam int LINES     = 256;
    localparam int IDX_W     = 8;
    localparam int ADDR_W    = 16;
    localparam int TAG_W     = 16;
    localparam int AGE_W     = 8;
    localparam int CNT_W     = 9;
    localparam int LOG_W     = 4;
    localparam int ENTRY_W   = 1 + TAG_W + AGE_W;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [2:0] ACT_RD    = 3'd0;
    localparam logic [2:0] ACT_WR    = 3'd1;
    localparam logic [2:0] ACT_FILL  = 3'd2;
    localparam logic [2:0] ACT_WB    = 3'd3;
    localparam logic [2:0] ACT_DROP  = 3'd4;

    localparam logic [1:0] REG_BLOCK = 2'd0;
    localparam logic [1:0] REG_SETS  = 2'd1;
    localparam logic [1:0] REG_WAYS  = 2'd2;

    typedef struct packed {
        logic [LOG_W-1:0] block_log2;
        logic [LOG_W-1:0] set_log2;
        logic [CNT_W-1:0] ways;
    } t_cfg;

    typedef struct packed {
        logic             dirty;
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
    } t_entry;
endpackage
`default_nettype wire

### sv/sawlc_if.sv
// Interfaces: access request channel and transfer report channel.
`default_nettype none
interface sawlc_req_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] address;
    modport source(output valid, mode, address, input ready);
    modport sink(input valid, mode, address, output ready);
endinterface

interface sawlc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [15:0] start_address;
    logic [8:0]  word_count;
    logic        was_hit;
    logic        last;
    modport source(output valid, action, start_address, word_count, was_hit, last,
                   input ready);
    modport sink(input valid, action, start_address, word_count, was_hit, last,
                 output ready);
endinterface
`default_nettype wire

### sv/set_assoc_writeback_lru_cache_unit.sv
// Top level: tag and LRU policy engine of a set-associative write-back cache.
//
//  channel | direction | transfer content
//  i_req   | in        | mode, address
//  o_rsp   | out       | action, start_address, word_count, was_hit, last
//  APB     | in        | block_size_log2, set_count_log2, ways
//
// For W ways, one tag memory read port walks the set once to search and once more to age
// and write back each way. Up to three transfers leave through an output register; a
// stalled sink holds the transfer states, not the walk.
// Reset is synchronous; line valid bits are flip-flops, so no clearing pass is needed.
`default_nettype none
module set_assoc_writeback_lru_cache_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    sawlc_req_if.sink                          i_req,
    sawlc_rsp_if.source                        o_rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sawlc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sawlc_pkg::PDATA_W-1:0] pwdata,
    output logic      [sawlc_pkg::PDATA_W-1:0] prdata,
    output logic                               pready
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SETUP = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_UPD   = 7'b0001000,
        ST_EVICT = 7'b0010000,
        ST_FILL  = 7'b0100000,
        ST_XFER  = 7'b1000000
    } t_state;

    localparam int IW = sawlc_pkg::IDX_W;
    localparam int CW = sawlc_pkg::CNT_W;
    localparam int AW = sawlc_pkg::ADDR_W;
    localparam int LINES_C = sawlc_pkg::LINES;

    sawlc_pkg::t_cfg   w_cfg;
    t_state            r_state;
    logic              r_mode;
    logic [AW-1:0]     r_addr;
    logic [3:0]        r_b;
    logic [3:0]        r_s;
    logic [CW-1:0]     r_w;
    logic [IW-1:0]     r_set;
    logic [IW-1:0]     r_base;
    logic [sawlc_pkg::TAG_W-1:0] r_tag;
    logic [CW-1:0]     r_rj;
    logic              r_pv;
    logic [CW-1:0]     r_pj;
    logic [IW-1:0]     r_pidx;
    logic              r_pval;
    logic [LINES_C-1:0] r_valid;
    logic              r_hit;
    logic [CW-1:0]     r_hj;
    logic [sawlc_pkg::AGE_W-1:0] r_hage;
    logic              r_found;
    logic [CW-1:0]     r_fj;
    logic [sawlc_pkg::AGE_W-1:0] r_best;
    logic [CW-1:0]     r_bj;
    logic [sawlc_pkg::TAG_W-1:0] r_btag;
    logic              r_bdirty;
    logic              r_ov;
    logic [2:0]        r_oact;
    logic [AW-1:0]     r_ostart;
    logic [CW-1:0]     r_ocnt;
    logic              r_ohit;
    logic              r_olast;

    logic              w_issue;
    logic [IW-1:0]     w_raddr;
    sawlc_pkg::t_entry w_rd;
    sawlc_pkg::t_entry w_wd;
    logic              w_we;
    logic [CW-1:0]     w_line_j;
    logic [CW-1:0]     w_old_age;
    logic              w_last_el;
    logic              w_oload;
    logic [3:0]        w_b;
    logic [3:0]        w_s;
    logic [CW-1:0]     w_cap;
    logic [CW-1:0]     w_w0;
    logic [CW-1:0]     w_w;
    logic [AW-1:0]     w_abs;
    logic [2*AW-1:0]   w_vwide;
    logic [AW-1:0]     w_vstart;
    logic [CW-1:0]     w_bsize;
    logic [2*CW-1:0]   w_prod;

    sawlc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sawlc_ram #(
        .WIDTH (sawlc_pkg::ENTRY_W),
        .DEPTH (LINES_C)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_pidx),
        .i_wdata (w_wd),
        .i_re    (w_issue),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    // Geometry of the next access, clamped to the array.
    assign w_b   = (w_cfg.block_log2 > 4'd8) ? 4'd8 : w_cfg.block_log2;
    assign w_s   = (w_cfg.set_log2 > 4'd8) ? 4'd8 : w_cfg.set_log2;
    assign w_cap = CW'(LINES_C) >> w_s;
    assign w_w0  = (w_cfg.ways == '0) ? CW'(1) : w_cfg.ways;
    assign w_w   = (w_w0 > w_cap) ? w_cap : w_w0;
    assign w_abs = i_req.address >> w_b;
    assign w_prod = {{(CW-IW){1'b0}}, r_set} * r_w;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_issue = ((r_state == ST_SCAN) || (r_state == ST_UPD)) && (r_rj < r_w);
    assign w_raddr = r_base + r_rj[IW-1:0];
    assign w_last_el = r_pv && (r_pj == r_w - CW'(1));

    assign w_line_j  = r_hit ? r_hj : (r_found ? r_fj : r_bj);
    assign w_old_age = r_hit ? {1'b0, r_hage} : CW'(LINES_C);
    assign w_we      = (r_state == ST_UPD) && r_pv;

    always_comb begin
        w_wd = w_rd;
        if (r_pj == w_line_j) begin
            w_wd.dirty = r_hit ? (w_rd.dirty | r_mode) : r_mode;
            w_wd.tag   = r_tag;
            w_wd.age   = '0;
        end else if (r_pval && ({1'b0, w_rd.age} < w_old_age) && (w_rd.age != 8'hFF)) begin
            w_wd.age = w_rd.age + 8'd1;
        end
    end

    assign w_bsize  = CW'(1) << r_b;
    assign w_vwide  = ({{AW{1'b0}}, r_btag} << ({1'b0, r_b} + {1'b0, r_s}))
                    | ({{(2*AW-IW){1'b0}}, r_set} << r_b);
    assign w_vstart = w_vwide[AW-1:0];
    assign w_oload  = !r_ov || o_rsp.ready;

    assign o_rsp.valid         = r_ov;
    assign o_rsp.action        = r_oact;
    assign o_rsp.start_address = r_ostart;
    assign o_rsp.word_count    = r_ocnt;
    assign o_rsp.was_hit       = r_ohit;
    assign o_rsp.last          = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_rj    <= '0;
        end else begin
            if (r_ov && o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            r_pv   <= w_issue;
            r_pj   <= r_rj;
            r_pidx <= w_raddr;
            r_pval <= r_valid[w_raddr];
            if (w_issue) begin
                r_rj <= r_rj + CW'(1);
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_mode  <= i_req.mode;
                        r_addr  <= i_req.address;
                        r_b     <= w_b;
                        r_s     <= w_s;
                        r_w     <= w_w;
                        r_set   <= w_abs[IW-1:0] & IW'((CW'(1) << w_s) - CW'(1));
                        r_tag   <= i_req.address >> ({1'b0, w_b} + {1'b0, w_s});
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_base  <= w_prod[IW-1:0];
                    r_rj    <= '0;
                    r_hit   <= 1'b0;
                    r_found <= 1'b0;
                    r_state <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_pv) begin
                        if (r_pval && (w_rd.tag == r_tag) && !r_hit) begin
                            r_hit  <= 1'b1;
                            r_hj   <= r_pj;
                            r_hage <= w_rd.age;
                        end
                        if (!r_pval && !r_found) begin
                            r_found <= 1'b1;
                            r_fj    <= r_pj;
                        end
                        if ((r_pj == '0) || (w_rd.age > r_best)) begin
                            r_best   <= w_rd.age;
                            r_bj     <= r_pj;
                            r_btag   <= w_rd.tag;
                            r_bdirty <= w_rd.dirty;
                        end
                    end
                    if (w_last_el) begin
                        r_rj    <= '0;
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (r_pv && (r_pj == w_line_j)) begin
                        r_valid[r_pidx] <= 1'b1;
                    end
                    if (w_last_el) begin
                        if (r_hit) begin
                            r_state <= ST_XFER;
                        end else if (r_found) begin
                            r_state <= ST_FILL;
                        end else begin
                            r_state <= ST_EVICT;
                        end
                    end
                end
                ST_EVICT: begin
                    if (w_oload) begin
                        r_ov     <= 1'b1;
                        r_oact   <= r_bdirty ? sawlc_pkg::ACT_WB : sawlc_pkg::ACT_DROP;
                        r_ostart <= w_vstart;
                        r_ocnt   <= w_bsize;
                        r_ohit   <= 1'b0;
                        r_olast  <= 1'b0;
                        r_state  <= ST_FILL;
                    end
                end
                ST_FILL: begin
                    if (w_oload) begin
                        r_ov     <= 1'b1;
                        r_oact   <= sawlc_pkg::ACT_FILL;
                        r_ostart <= r_addr & ~AW'(w_bsize - CW'(1));
                        r_ocnt   <= w_bsize;
                        r_ohit   <= 1'b0;
                        r_olast  <= 1'b0;
                        r_state  <= ST_XFER;
                    end
                end
                ST_XFER: begin
                    if (w_oload) begin
                        r_ov     <= 1'b1;
                        r_oact   <= r_mode ? sawlc_pkg::ACT_WR : sawlc_pkg::ACT_RD;
                        r_ostart <= r_addr;
                        r_ocnt   <= CW'(1);
                        r_ohit   <= r_hit;
                        r_olast  <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_evict_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVICT) |-> (!r_hit && !r_found))
        else $error("eviction with a hit or a free way");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_pj < r_w))
        else $error("way walk beyond the set");
    a_line_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (w_line_j < r_w))
        else $error("selected way outside the set");
`endif
endmodule
`default_nettype wire

### sv/sawlc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sawlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### sv/sawlc_cfg.sv
// APB configuration registers: block size, set count and associativity.
`default_nettype none
module sawlc_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sawlc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [sawlc_pkg::PDATA_W-1:0] pwdata,
    output logic      [sawlc_pkg::PDATA_W-1:0] prdata,
    output logic                               pready,
    output sawlc_pkg::t_cfg                    o_cfg
);
    sawlc_pkg::t_cfg r_cfg;
    logic [1:0]      w_idx;

    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_log2 <= '0;
            r_cfg.set_log2   <= '0;
            r_cfg.ways       <= sawlc_pkg::CNT_W'(1);
        end else if (psel && penable && pwrite) begin
            if (w_idx == sawlc_pkg::REG_BLOCK) begin
                r_cfg.block_log2 <= pwdata[sawlc_pkg::LOG_W-1:0];
            end else if (w_idx == sawlc_pkg::REG_SETS) begin
                r_cfg.set_log2 <= pwdata[sawlc_pkg::LOG_W-1:0];
            end else if (w_idx == sawlc_pkg::REG_WAYS) begin
                r_cfg.ways <= pwdata[sawlc_pkg::CNT_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (w_idx == sawlc_pkg::REG_BLOCK) begin
            prdata[sawlc_pkg::LOG_W-1:0] = r_cfg.block_log2;
        end else if (w_idx == sawlc_pkg::REG_SETS) begin
            prdata[sawlc_pkg::LOG_W-1:0] = r_cfg.set_log2;
        end else if (w_idx == sawlc_pkg::REG_WAYS) begin
            prdata[sawlc_pkg::CNT_W-1:0] = r_cfg.ways;
        end
    end
endmodule
`default_nettype wire

### tb/tb_top.sv
// Testbench for the set-associative write-back LRU cache tag engine: predictor and checker.
`timescale 1ns / 100ps
module tb_top;
    import sawlc_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES = 2 * 256 + 64;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] start_address;
        logic [8:0]  word_count;
        logic        was_hit;
        logic        last;
    } t_xfer;

    class cache_scoreboard;
        logic            valid_q [LINES];
        logic            dirty_q [LINES];
        logic [15:0]     tag_q [LINES];
        logic [7:0]      age_q [LINES];
        logic [3:0]      block_log2;
        logic [3:0]      set_log2;
        logic [8:0]      way_cfg;
        t_xfer           pending[$];
        int              mismatches;

        function void reset_state();
            for (int i = 0; i < LINES; i++) begin
                valid_q[i] = 0;
                dirty_q[i] = 0;
                tag_q[i] = '0;
                age_q[i] = '0;
            end
            block_log2 = 0;
            set_log2 = 0;
            way_cfg = 1;
            mismatches = 0;
        endfunction

        function void write_reg(int idx, logic [31:0] value);
            if (idx == REG_BLOCK) block_log2 = value[3:0];
            else if (idx == REG_SETS) set_log2 = value[3:0];
            else if (idx == REG_WAYS) way_cfg = value[8:0];
        endfunction

        function void push(logic [2:0] act, int start, int cnt, logic hit, logic lst);
            t_xfer x;
            x.action = act;
            x.start_address = start[15:0];
            x.word_count = cnt[8:0];
            x.was_hit = hit;
            x.last = lst;
            pending.push_back(x);
        endfunction

        function void note_access(logic mode, logic [15:0] addr);
            int b, s, w, cap, set, base, line, old_age, best, bsize, tag, a;
            bit hit, found;
            b = (block_log2 > 8) ? 8 : block_log2;
            s = (set_log2 > 8) ? 8 : set_log2;
            cap = LINES >> s;
            w = (way_cfg == 0) ? 1 : way_cfg;
            if (w > cap) w = cap;
            a = addr;
            bsize = 1 << b;
            set = (a >> b) & ((1 << s) - 1);
            tag = (a >> (b + s)) & 16'hFFFF;
            base = set * w;
            hit = 0;
            found = 0;
            line = 0;
            for (int j = 0; j < w; j++) begin
                if (!hit && valid_q[base + j] && tag_q[base + j] == tag) begin
                    line = base + j;
                    hit = 1;
                end
            end
            if (hit) begin
                old_age = age_q[line];
            end else begin
                for (int j = 0; j < w; j++) begin
                    if (!found && !valid_q[base + j]) begin
                        line = base + j;
                        found = 1;
                    end
                end
                if (!found) begin
                    best = 0;
                    line = base;
                    for (int j = 0; j < w; j++) begin
                        if (j == 0 || age_q[base + j] > best) begin
                            best = age_q[base + j];
                            line = base + j;
                        end
                    end
                    push(dirty_q[line] ? ACT_WB : ACT_DROP,
                         (int'(tag_q[line]) << (b + s)) | (set << b), bsize, 0, 0);
                end
                valid_q[line] = 1;
                dirty_q[line] = 0;
                tag_q[line] = tag[15:0];
                push(ACT_FILL, a & ~(bsize - 1), bsize, 0, 0);
                old_age = 256;
            end
            for (int j = 0; j < w; j++) begin
                if (base + j != line && valid_q[base + j] && age_q[base + j] < old_age
                        && age_q[base + j] < 255)
                    age_q[base + j] = age_q[base + j] + 1;
            end
            age_q[line] = 0;
            if (mode) dirty_q[line] = 1;
            push(mode ? ACT_WR : ACT_RD, a, 1, hit, 1);
        endfunction

        function void check_xfer(t_xfer got);
            t_xfer exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected transfer %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: transfer mismatch expected %p actual %p", exp, got);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic        pready;

    sawlc_req_if req ();
    sawlc_rsp_if rsp ();

    set_assoc_writeback_lru_cache_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req.sink),
        .o_rsp   (rsp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cache_scoreboard sb;
    int tx_idle = 21;
    int rx_idle = 50;
    int sent = 0;
    int cycles = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    initial begin
        req.valid = 0;
        req.mode = 0;
        req.address = '0;
        rsp.ready = 0;
        sb = new();
        sb.reset_state();
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL set_assoc_writeback_lru_cache_unit");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        rsp.ready <= ($urandom_range(0, 99) >= rx_idle);
        if (i_rst_n && rsp.valid && rsp.ready)
            sb.check_xfer({rsp.action, rsp.start_address, rsp.word_count,
                           rsp.was_hit, rsp.last});
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.write_reg(idx, value);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(int blog, int slog, int nways);
        wait_drained();
        apb_write(REG_BLOCK, blog);
        apb_write(REG_SETS, slog);
        apb_write(REG_WAYS, nways);
    endtask

    task automatic send_access(logic mode, logic [15:0] addr);
        if (sent == 160) begin
            tx_idle = 50;
            rx_idle = 21;
        end else if (sent == 320) begin
            tx_idle = 0;
            rx_idle = 0;
        end
        while ($urandom_range(0, 99) < tx_idle) begin
            req.valid <= 0;
            @(posedge i_clk);
        end
        req.valid <= 1;
        req.mode <= mode;
        req.address <= addr;
        do @(posedge i_clk); while (!(req.valid && req.ready));
        sb.note_access(mode, addr);
        sent++;
    endtask

    task automatic run_phase(int blog, int slog, int nways, int count, bit pause);
        int b, s, w, span;
        configure(blog, slog, nways);
        b = (blog > 8) ? 8 : blog;
        s = (slog > 8) ? 8 : slog;
        w = (nways == 0) ? 1 : nways;
        if (w > (LINES >> s)) w = LINES >> s;
        span = (1 << b) * (1 << s) * w * 2;
        if (span > 65536) span = 65536;
        for (int k = 0; k < count; k++) begin
            if (pause && k == count / 2) begin
                @(posedge i_clk);
                req.valid <= 0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 99) < 20)
                send_access($urandom_range(0, 1), $urandom_range(0, 65535));
            else
                send_access($urandom_range(0, 1), $urandom_range(0, span - 1));
        end
        @(posedge i_clk);
        req.valid <= 0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        configure(0, 0, 1);
        send_access(0, 16'h0000);
        send_access(1, 16'h0000);
        send_access(1, 16'hFFFF);
        send_access(0, 16'hFFFF);
        send_access(0, 16'h0000);
        send_access(1, 16'h8000);
        send_access(0, 16'h7FFF);
        @(posedge i_clk);
        req.valid <= 0;
        configure(2, 1, 2);
        send_access(0, 16'h0005);
        send_access(1, 16'h0105);
        send_access(0, 16'h0205);
        send_access(0, 16'h0005);
        send_access(1, 16'h0305);
        send_access(0, 16'h0000);
        @(posedge i_clk);
        req.valid <= 0;
        configure(15, 15, 0);
        send_access(1, 16'hABCD);
        send_access(0, 16'h1234);
        send_access(0, 16'hABCD);
        @(posedge i_clk);
        req.valid <= 0;
        run_phase(2, 2, 4, 80, 1);
        run_phase(8, 0, 1, 30, 0);
        run_phase(0, 8, 1, 60, 0);
        run_phase(1, 3, 8, 80, 0);
        run_phase(3, 0, 256, 25, 0);
        run_phase(15, 15, 0, 40, 0);
        run_phase(4, 1, 200, 25, 0);
        run_phase(0, 0, 1, 60, 0);
        run_phase(1, 2, 3, 60, 0);
        wait_drained();
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("PASS set_assoc_writeback_lru_cache_unit");
        end else begin
            $display("FAIL set_assoc_writeback_lru_cache_unit");
        end
        $finish;
    end
endmodule
